[rtl/klw_pkg.sv]
`default_nettype none
package klw_pkg;

    localparam int CH_W = 16;
    localparam int COL_W = 16;
    localparam int LW_W = 10;
    localparam int TAB_W = 6;
    localparam int CNT_W = 6;
    localparam int IX_W = 5;
    localparam int Q_DEPTH = 4;
    localparam int TAB_MAX = 32;

    localparam logic [1:0] OP_CHAR = 2'd0;
    localparam logic [1:0] OP_EOT = 2'd1;
    localparam logic [1:0] OP_LOAD_PUSH = 2'd2;
    localparam logic [1:0] OP_LOAD_HANG = 2'd3;

    localparam logic [1:0] CFG_LINE_WIDTH = 2'd0;
    localparam logic [1:0] CFG_TAB_SIZE = 2'd1;
    localparam logic [1:0] CFG_PUSH_COUNT = 2'd2;
    localparam logic [1:0] CFG_HANG_COUNT = 2'd3;

    localparam logic [CH_W-1:0] CODE_CR = 16'd13;
    localparam logic [CH_W-1:0] CODE_LF = 16'd10;
    localparam logic [CH_W-1:0] CODE_TAB = 16'd9;
    localparam logic [CH_W-1:0] CODE_SPACE = 16'd32;
    localparam logic [CH_W-1:0] CODE_APOS = 16'd39;

    // classified text beat queued between front and back
    typedef struct packed {
        logic            eot;
        logic [CH_W-1:0] ch;
        logic            word;
        logic            push;
        logic            hang;
    } t_item;

endpackage
`default_nettype wire

[rtl/kinsoku_line_wrapper_top.sv]
`default_nettype none
// line wrapper for a stream of 16-bit characters: inserts CR LF so text fits
// line_width columns, keeping runs of letters, digits and apostrophes (plus
// one trailing space) whole, honoring tab stops, push-out and hanging lists.
// a front end takes one beat per cycle while its four-entry queue has room,
// loading list entries and matching each character against both lists in
// parallel. the back end works one queued beat at a time: a word character
// is buffered in the word store, and on a flush each stored word character
// is read from the word store, then output; each other character is output
// after bookkeeping, a tab after finding the column remainder one bit per
// cycle. output beats leave from a register, so states that emit nothing
// keep working while a beat waits on stall.
// configuration must be written only while the block is idle.
module kinsoku_line_wrapper_top import klw_pkg::*; #(
    parameter int LIST_DEPTH = 32,
    parameter int WORD_MAX = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // text and list load beats
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire logic [1:0]       i_op,
    input  wire logic [CH_W-1:0]  i_ch,
    input  wire logic [IX_W-1:0]  i_index,
    // wrapped output beats
    output logic                  o_valid,
    input  wire logic             i_stall,
    output logic [CH_W-1:0]       o_out_char,
    output logic                  o_last,
    // configuration writes
    input  wire logic             i_cfg_we,
    input  wire logic [1:0]       i_cfg_index,
    input  wire logic [LW_W-1:0]  i_cfg_data
);

    logic [LW_W-1:0]  r_line_width;
    logic [TAB_W-1:0] r_tab_size;
    logic [CNT_W-1:0] r_push_count;
    logic [CNT_W-1:0] r_hang_count;

    logic  q_push;
    logic  q_pop;
    logic  q_full;
    logic  q_empty;
    t_item f_item;
    t_item q_item;

    // register file: line width resets to 0, tab size to 8, list counts to 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= '0;
            r_tab_size   <= TAB_W'(8);
            r_push_count <= '0;
            r_hang_count <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LINE_WIDTH: r_line_width <= i_cfg_data;
                CFG_TAB_SIZE:   r_tab_size   <= i_cfg_data[TAB_W-1:0];
                CFG_PUSH_COUNT: r_push_count <= i_cfg_data[CNT_W-1:0];
                CFG_HANG_COUNT: r_hang_count <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // front: list storage and character classification
    klw_front #(
        .LIST_DEPTH(LIST_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_valid      (i_valid),
        .i_op         (i_op),
        .i_ch         (i_ch),
        .i_index      (i_index),
        .i_push_count (r_push_count),
        .i_hang_count (r_hang_count),
        .i_full       (q_full),
        .o_stall      (o_stall),
        .o_push       (q_push),
        .o_item       (f_item)
    );

    // decouples classification from the emitting sequencer
    klw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (f_item),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_item  (q_item)
    );

    // back: word store, column tracking and output sequencing
    klw_back #(
        .WORD_MAX(WORD_MAX)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_line_width (r_line_width),
        .i_tab_size   (r_tab_size),
        .i_empty      (q_empty),
        .i_item       (q_item),
        .o_pop        (q_pop),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_out_char   (o_out_char),
        .o_last       (o_last)
    );

endmodule
`default_nettype wire

[rtl/klw_front.sv]
`default_nettype none
module klw_front import klw_pkg::*; #(
    parameter int LIST_DEPTH = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_valid,
    input  wire logic [1:0]       i_op,
    input  wire logic [CH_W-1:0]  i_ch,
    input  wire logic [IX_W-1:0]  i_index,
    input  wire logic [CNT_W-1:0] i_push_count,
    input  wire logic [CNT_W-1:0] i_hang_count,
    input  wire logic             i_full,
    output logic                  o_stall,
    output logic                  o_push,
    output t_item                 o_item
);

    localparam int LI_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

    logic [CH_W-1:0] r_push_list [LIST_DEPTH];
    logic [CH_W-1:0] r_hang_list [LIST_DEPTH];

    logic            accept;
    logic            in_range;
    logic [LI_W-1:0] widx;
    logic            push_hit;
    logic            hang_hit;
    logic            word_ch;

    assign o_stall  = i_full;
    assign accept   = i_valid && !i_full;
    assign in_range = int'(i_index) < LIST_DEPTH;
    assign widx     = LI_W'(i_index);

    always_ff @(posedge i_clk) begin
        if (accept && in_range && i_op == OP_LOAD_PUSH) begin
            r_push_list[widx] <= i_ch;
        end
        if (accept && in_range && i_op == OP_LOAD_HANG) begin
            r_hang_list[widx] <= i_ch;
        end
    end

    // parallel compare against every live slot
    always_comb begin
        push_hit = 1'b0;
        hang_hit = 1'b0;
        for (int j = 0; j < LIST_DEPTH; j++) begin
            if (j < int'(i_push_count) && r_push_list[j] == i_ch) begin
                push_hit = 1'b1;
            end
            if (j < int'(i_hang_count) && r_hang_list[j] == i_ch) begin
                hang_hit = 1'b1;
            end
        end
    end

    assign word_ch = (i_ch >= 16'd97 && i_ch <= 16'd122) || (i_ch >= 16'd65 && i_ch <= 16'd90)
                  || (i_ch >= 16'd48 && i_ch <= 16'd57) || i_ch == CODE_APOS;

    assign o_push      = accept && (i_op == OP_CHAR || i_op == OP_EOT);
    assign o_item.eot  = (i_op == OP_EOT);
    assign o_item.ch   = i_ch;
    assign o_item.word = word_ch;
    assign o_item.push = push_hit;
    assign o_item.hang = hang_hit && !push_hit;

endmodule
`default_nettype wire

[rtl/klw_queue.sv]
`default_nettype none
module klw_queue import klw_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  t_item      i_item,
    input  wire logic  i_pop,
    output logic       o_full,
    output logic       o_empty,
    output t_item      o_item
);

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_QW = $clog2(Q_DEPTH + 1);

    t_item              r_mem [Q_DEPTH];
    logic [PTR_W-1:0]   r_wptr;
    logic [PTR_W-1:0]   r_rptr;
    logic [CNT_QW-1:0]  r_cnt;

    assign o_full  = (r_cnt == CNT_QW'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

[rtl/klw_back.sv]
`default_nettype none
module klw_back import klw_pkg::*; #(
    parameter int WORD_MAX = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [LW_W-1:0]  i_line_width,
    input  wire logic [TAB_W-1:0] i_tab_size,
    input  wire logic             i_empty,
    input  t_item                 i_item,
    output logic                  o_pop,
    input  wire logic             i_stall,
    output logic                  o_valid,
    output logic [CH_W-1:0]       o_out_char,
    output logic                  o_last
);

    localparam int DEPTH = WORD_MAX + 1;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int WL_W = $clog2(DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_FLUSH, S_CR1, S_LF1, S_RD, S_WD, S_AFTER,
        S_CHDEC, S_DIV, S_CR2, S_LF2, S_CH
    } t_state;

    t_state            r_state;
    t_item             r_item;
    logic              r_wrap;
    logic              r_has_char;
    logic              r_raw;
    logic              r_store;
    logic [WL_W-1:0]   r_wl;
    logic [COL_W-1:0]  r_col;
    logic              r_ar;
    logic [IDX_W-1:0]  r_idx;
    logic [5:0]        r_rem;
    logic [3:0]        r_cnt;
    logic [CH_W-1:0]   r_rdata;
    logic [CH_W-1:0]   r_mem [DEPTH];

    logic              free;
    logic              send;
    logic              big;
    logic              space_end;
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [CH_W-1:0]   wdata;
    logic [COL_W:0]    flush_sum;
    logic [COL_W:0]    next_col;
    logic [TAB_W-1:0]  tab;
    logic [5:0]        rem_sh;
    logic [5:0]        rem_n;
    logic [COL_W:0]    tab_n;
    logic              last_rd;
    logic              crlf_ch;

    assign free      = !o_valid || !i_stall;
    assign send      = free && (r_state inside {S_CR1, S_LF1, S_WD, S_CR2, S_LF2, S_CH});
    assign o_pop     = (r_state == S_IDLE) && !i_empty;
    assign big       = r_wl >= WL_W'(WORD_MAX);
    assign space_end = (i_item.ch == CODE_SPACE) && (r_wl != '0);
    assign flush_sum = {1'b0, r_col} + (COL_W + 1)'(r_wl);
    assign next_col  = {1'b0, r_col} + 1'b1;
    assign last_rd   = (WL_W'(r_idx) + 1'b1) == r_wl;

    // other characters: push-out breaks one column early, hanging may overrun
    always_comb begin
        logic ge;
        logic gt;
        logic eq;
        ge = next_col >= (COL_W + 1)'(i_line_width);
        gt = next_col > (COL_W + 1)'(i_line_width);
        eq = next_col == (COL_W + 1)'(i_line_width);
        crlf_ch = (gt && !(ge && r_item.hang)) || (eq && r_item.push);
    end

    // tab remainder, one column bit per cycle
    always_comb begin
        if (i_tab_size == '0) begin
            tab = TAB_W'(1);
        end else if (i_tab_size > TAB_W'(TAB_MAX)) begin
            tab = TAB_W'(TAB_MAX);
        end else begin
            tab = i_tab_size;
        end
        rem_sh = {r_rem[4:0], r_col[4'd15 - r_cnt]};
        rem_n  = (rem_sh >= tab) ? rem_sh - tab : rem_sh;
        tab_n  = {1'b0, r_col} + (COL_W + 1)'(tab) - (COL_W + 1)'(rem_n);
    end

    always_comb begin
        we    = 1'b0;
        waddr = r_wl[IDX_W-1:0];
        wdata = i_item.ch;
        if (o_pop && !i_item.eot && i_line_width != '0 && !r_ar) begin
            we = (i_item.word && !big) || (!i_item.word && space_end);
        end
        if (r_state == S_AFTER && r_store) begin
            we    = 1'b1;
            waddr = '0;
            wdata = r_item.ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rdata <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_wl       <= '0;
            r_col      <= '0;
            r_ar       <= 1'b0;
            o_valid    <= 1'b0;
            r_item     <= '0;
            r_wrap     <= 1'b0;
            r_has_char <= 1'b0;
            r_raw      <= 1'b0;
            r_store    <= 1'b0;
            r_idx      <= '0;
            r_rem      <= '0;
            r_cnt      <= '0;
            o_out_char <= '0;
            o_last     <= 1'b0;
        end else begin
            if (send) begin
                o_valid <= 1'b1;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_item     <= i_item;
                        r_wrap     <= 1'b1;
                        r_has_char <= 1'b0;
                        r_raw      <= 1'b0;
                        r_store    <= 1'b0;
                        if (i_item.eot) begin
                            r_wrap  <= (i_line_width != '0);
                            r_state <= S_FLUSH;
                        end else if (i_line_width == '0) begin
                            r_wrap     <= 1'b0;
                            r_has_char <= 1'b1;
                            r_raw      <= 1'b1;
                            r_ar       <= 1'b0;
                            r_state    <= S_FLUSH;
                        end else if (r_ar) begin
                            r_ar       <= 1'b0;
                            r_has_char <= 1'b1;
                            r_raw      <= 1'b1;
                            r_state    <= S_CH;
                        end else if (i_item.word) begin
                            if (big) begin
                                r_store <= 1'b1;
                                r_state <= S_FLUSH;
                            end else begin
                                r_wl <= r_wl + 1'b1;
                            end
                        end else if (space_end) begin
                            r_wl    <= r_wl + 1'b1;
                            r_state <= S_FLUSH;
                        end else begin
                            r_has_char <= 1'b1;
                            r_state    <= S_FLUSH;
                        end
                    end
                end
                S_FLUSH: begin
                    r_idx <= '0;
                    if (r_wl == '0) begin
                        r_state <= S_AFTER;
                    end else if (r_wrap && flush_sum > (COL_W + 1)'(i_line_width)) begin
                        r_col   <= COL_W'(r_wl);
                        r_state <= (r_col != '0) ? S_CR1 : S_RD;
                    end else begin
                        if (r_wrap) begin
                            r_col <= flush_sum[COL_W] ? '1 : flush_sum[COL_W-1:0];
                        end
                        r_state <= S_RD;
                    end
                end
                S_CR1: begin
                    if (free) begin
                        o_out_char <= CODE_CR;
                        o_last     <= 1'b0;
                        r_state    <= S_LF1;
                    end
                end
                S_LF1: begin
                    if (free) begin
                        o_out_char <= CODE_LF;
                        o_last     <= 1'b0;
                        r_state    <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_WD;
                end
                S_WD: begin
                    if (free) begin
                        o_out_char <= r_rdata;
                        o_last     <= last_rd && !r_has_char;
                        if (last_rd) begin
                            r_wl    <= '0;
                            r_state <= S_AFTER;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_RD;
                        end
                    end
                end
                S_AFTER: begin
                    if (r_store) begin
                        r_wl    <= WL_W'(1);
                        r_state <= S_IDLE;
                    end else if (r_item.eot) begin
                        r_col   <= '0;
                        r_ar    <= 1'b0;
                        r_state <= S_IDLE;
                    end else if (r_has_char) begin
                        r_state <= r_raw ? S_CH : S_CHDEC;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_CHDEC: begin
                    if (r_item.ch == CODE_CR) begin
                        r_col   <= '0;
                        r_ar    <= 1'b1;
                        r_state <= S_CH;
                    end else if (r_item.ch == CODE_TAB) begin
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end else if (crlf_ch) begin
                        r_col   <= COL_W'(1);
                        r_state <= S_CR2;
                    end else begin
                        r_col   <= next_col[COL_W] ? '1 : next_col[COL_W-1:0];
                        r_state <= S_CH;
                    end
                end
                S_DIV: begin
                    r_rem <= rem_n;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 4'd15) begin
                        if (tab_n > (COL_W + 1)'(i_line_width)) begin
                            r_col   <= COL_W'(tab);
                            r_state <= S_CR2;
                        end else begin
                            r_col   <= tab_n[COL_W] ? '1 : tab_n[COL_W-1:0];
                            r_state <= S_CH;
                        end
                    end
                end
                S_CR2: begin
                    if (free) begin
                        o_out_char <= CODE_CR;
                        o_last     <= 1'b0;
                        r_state    <= S_LF2;
                    end
                end
                S_LF2: begin
                    if (free) begin
                        o_out_char <= CODE_LF;
                        o_last     <= 1'b0;
                        r_state    <= S_CH;
                    end
                end
                S_CH: begin
                    if (free) begin
                        o_out_char <= r_item.ch;
                        o_last     <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire
